### rtl/swc_pkg.sv
// Shared types and constants for the scan curvature window.
// No dependencies; imported by every module of the block.
package swc_pkg;

  localparam int CURV_BITS       = 57;
  localparam int IDX_BITS        = 17;
  localparam int SQ_IN_BITS      = 29;
  localparam int SQ_BITS         = 2 * SQ_IN_BITS;
  localparam int AXES            = 3;

  localparam int DEF_MAX_POINTS  = 131072;
  localparam int DEF_HALF_WINDOW = 5;
  localparam int DEF_COORD_BITS  = 24;

  localparam logic [CURV_BITS-1:0] CURV_MAX = {CURV_BITS{1'b1}};

  typedef struct packed {
    logic               sat;
    logic [SQ_BITS-1:0] sq;
  } sq_res_t;

endpackage

### rtl/swc_cell.sv
// One window cell: holds a point and hands it to its older neighbor.
// Depends on swc_pkg.
module swc_cell
  import swc_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              shift_en,
  input  logic [AXES-1:0][COORD_BITS-1:0]   pt_in,
  output logic [AXES-1:0][COORD_BITS-1:0]   pt_out
);

  logic [AXES-1:0][COORD_BITS-1:0] pt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r <= '0;
    end else if (shift_en) begin
      pt_r <= pt_in;
    end
  end

  assign pt_out = pt_r;

endmodule

### rtl/swc_square.sv
// Registered saturating square of one axis difference.
// Depends on swc_pkg.
module swc_square
  import swc_pkg::*;
#(
  parameter int D_BITS = 32
) (
  input  logic                     clk,
  input  logic                     load_en,
  input  logic signed [D_BITS-1:0] diff,
  output sq_res_t                  res
);

  localparam int AW = (D_BITS > SQ_IN_BITS + 1) ? D_BITS : SQ_IN_BITS + 1;

  logic [D_BITS-1:0]     mag;
  logic [AW-1:0]         mag_ext;
  logic [SQ_IN_BITS-1:0] mag_lo;
  sq_res_t               res_r;
  sq_res_t               res_nxt;

  always_comb begin
    mag           = diff[D_BITS-1] ? D_BITS'(-diff) : D_BITS'(diff);
    mag_ext       = AW'(mag);
    mag_lo        = mag_ext[SQ_IN_BITS-1:0];
    res_nxt.sat   = |mag_ext[AW-1:SQ_IN_BITS];
    res_nxt.sq    = SQ_BITS'(mag_lo) * SQ_BITS'(mag_lo);
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### rtl/scan_curvature_window.sv
// Top level of the scan curvature window: cell chain, running sums, output pipe.
// Depends on swc_pkg, swc_cell and swc_square.
//
// Usage: points of an ordered cloud enter on the in_ channel, one item per
// accepted cycle, with in_end_of_cloud set on the last point of each cloud.
// For every point that completes a window of 2*HALF_WINDOW+1 points of the
// current cloud, one item leaves on the out_ channel: the curvature of the
// center point, its index in the cloud and a flag on the last result of the
// cloud. The first and last HALF_WINDOW points of a cloud give no item.
// Throughput is one point per cycle while in_stall is low. A result reaches
// out_valid through three registered stages in order: the accepting edge loads
// the axis differences, then the squares are loaded, then the sum and
// saturation in the output register. When the receiver stalls, each stage
// holds its item while stages behind it fill their bubbles; in_stall rises
// only when all three stages hold an item and out_stall is high.
// Reset clears the window cells, the running sums, the point counter and all
// stage valid bits; the block accepts items in the first cycle after reset.
module scan_curvature_window
  import swc_pkg::*;
#(
  parameter int MAX_POINTS  = DEF_MAX_POINTS,
  parameter int HALF_WINDOW = DEF_HALF_WINDOW,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic signed [COORD_BITS-1:0] in_z_coord,
  input  logic                         in_end_of_cloud,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CURV_BITS-1:0]         out_curvature,
  output logic [IDX_BITS-1:0]          out_point_index,
  output logic                         out_last_result
);

  localparam int WIN_LEN   = 2 * HALF_WINDOW;
  localparam int CNT_BITS  = $clog2(MAX_POINTS);
  localparam int SUM_BITS  = COORD_BITS + $clog2(WIN_LEN) + 1;
  localparam int D_BITS    = COORD_BITS + $clog2(WIN_LEN + 1) + 2;
  localparam int TOT_BITS  = SQ_BITS + 2;
  localparam logic [CNT_BITS:0]        WIN_CNT  = (CNT_BITS+1)'(WIN_LEN);
  localparam logic [CNT_BITS:0]        HALF_CNT = (CNT_BITS+1)'(HALF_WINDOW);
  localparam logic [CNT_BITS-1:0]      CNT_TOP  = CNT_BITS'(MAX_POINTS - 1);
  localparam logic signed [D_BITS-1:0] CTR_MUL  = D_BITS'(WIN_LEN + 1);

  logic                              in_acc;
  logic                              en_a;
  logic                              en_b;
  logic                              en_c;
  logic                              produce;
  logic [AXES-1:0][COORD_BITS-1:0]   in_pt;
  logic [AXES-1:0][COORD_BITS-1:0]   win [WIN_LEN+1];
  logic signed [SUM_BITS-1:0]        sum_r   [AXES];
  logic signed [SUM_BITS-1:0]        sum_nxt [AXES];
  logic signed [D_BITS-1:0]          diff_r  [AXES];
  logic signed [D_BITS-1:0]          diff_nxt[AXES];
  sq_res_t                           sq_res  [AXES];
  logic [CNT_BITS-1:0]               cnt_r;
  logic [CNT_BITS-1:0]               cnt_nxt;
  logic [CNT_BITS:0]                 idx_diff;
  logic                              va_r;
  logic                              la_r;
  logic [IDX_BITS-1:0]               ia_r;
  logic                              vb_r;
  logic                              lb_r;
  logic [IDX_BITS-1:0]               ib_r;
  logic                              out_valid_r;
  logic                              out_last_r;
  logic [IDX_BITS-1:0]               out_idx_r;
  logic [CURV_BITS-1:0]              out_curv_r;
  logic [TOT_BITS-1:0]               tot;
  logic                              tot_sat;
  logic [CURV_BITS-1:0]              curv_nxt;

  assign en_c     = !out_valid_r || !out_stall;
  assign en_b     = !vb_r || en_c;
  assign en_a     = !va_r || en_b;
  assign in_stall = !en_a;
  assign in_acc   = in_valid && en_a;

  assign in_pt[0] = in_x_coord;
  assign in_pt[1] = in_y_coord;
  assign in_pt[2] = in_z_coord;

  // win[0] is the oldest point; win[WIN_LEN] feeds the newest cell
  assign win[WIN_LEN] = in_pt;

  for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
    swc_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_en(in_acc),
      .pt_in   (win[k+1]),
      .pt_out  (win[k])
    );
  end

  assign produce  = {1'b0, cnt_r} >= WIN_CNT;
  assign idx_diff = {1'b0, cnt_r} - HALF_CNT;

  always_comb begin
    if (in_end_of_cloud) begin
      cnt_nxt = '0;
    end else if (cnt_r < CNT_TOP) begin
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    always_comb begin
      sum_nxt[a]  = sum_r[a] - SUM_BITS'($signed(win[0][a]))
                  + SUM_BITS'($signed(in_pt[a]));
      diff_nxt[a] = D_BITS'(sum_r[a]) + D_BITS'($signed(in_pt[a]))
                  - CTR_MUL * D_BITS'($signed(win[HALF_WINDOW][a]));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sum_r[a] <= '0;
      end else if (in_acc) begin
        sum_r[a] <= sum_nxt[a];
      end
    end

    always_ff @(posedge clk) begin
      if (en_a) begin
        diff_r[a] <= diff_nxt[a];
      end
    end

    swc_square #(
      .D_BITS(D_BITS)
    ) u_square (
      .clk    (clk),
      .load_en(en_b),
      .diff   (diff_r[a]),
      .res    (sq_res[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) begin
        va_r <= in_acc && produce;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
      if (en_c) begin
        out_valid_r <= vb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      la_r <= in_end_of_cloud;
      ia_r <= IDX_BITS'(idx_diff);
    end
    if (en_b) begin
      lb_r <= la_r;
      ib_r <= ia_r;
    end
    if (en_c) begin
      out_last_r <= lb_r;
      out_idx_r  <= ib_r;
      out_curv_r <= curv_nxt;
    end
  end

  always_comb begin
    tot      = TOT_BITS'(sq_res[0].sq) + TOT_BITS'(sq_res[1].sq)
             + TOT_BITS'(sq_res[2].sq);
    tot_sat  = sq_res[0].sat || sq_res[1].sat || sq_res[2].sat
             || (tot > TOT_BITS'(CURV_MAX));
    curv_nxt = tot_sat ? CURV_MAX : CURV_BITS'(tot);
  end

  assign out_valid       = out_valid_r;
  assign out_curvature   = out_curv_r;
  assign out_point_index = out_idx_r;
  assign out_last_result = out_last_r;

  a_short_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !produce) |=> !va_r)
    else $error("result started before the window was full");

  a_cloud_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_cloud) |=> (cnt_r == '0))
    else $error("point counter not cleared at end of cloud");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (va_r && vb_r && out_valid_r && out_stall))
    else $error("input stalled with a free pipeline stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && !en_c) |=> vb_r)
    else $error("square stage dropped an item under stall");

endmodule

### tb/scan_curvature_window_test.sv
// Self-checking testbench for scan_curvature_window: directed and random clouds,
// predicted curvature compared item by item. Depends on swc_pkg and the RTL.
module scan_curvature_window_test;
  import swc_pkg::*;

  localparam int MAX_POINTS   = DEF_MAX_POINTS;
  localparam int HALF_WINDOW  = DEF_HALF_WINDOW;
  localparam int COORD_BITS   = DEF_COORD_BITS;
  localparam int WIN_LEN      = 2 * HALF_WINDOW;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 80;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum int {STYLE_WIDE, STYLE_NEAR, STYLE_EDGE} coord_style_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         eoc;
  } point_t;

  typedef struct packed {
    logic [CURV_BITS-1:0] curvature;
    logic [IDX_BITS-1:0]  point_index;
    logic                 last_result;
  } curv_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] in_x_coord = '0;
  logic signed [COORD_BITS-1:0] in_y_coord = '0;
  logic signed [COORD_BITS-1:0] in_z_coord = '0;
  logic                         in_end_of_cloud = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [CURV_BITS-1:0]         out_curvature;
  logic [IDX_BITS-1:0]          out_point_index;
  logic                         out_last_result;

  point_t       pending_points[$];
  curv_result_t curvature_due[$];
  point_t       staged_point;
  point_t       driven_point;
  curv_result_t oldest_due;

  logic signed [COORD_BITS-1:0] win[AXES][WIN_LEN];
  int points_seen = 0;

  int queued_total = 0;
  int accepted_total = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;

  int idle_table[4]  = '{0, 51, 0, 6};
  int stall_table[4] = '{0, 0, 51, 6};

  scan_curvature_window u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_z_coord      (in_z_coord),
    .in_end_of_cloud (in_end_of_cloud),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_curvature   (out_curvature),
    .out_point_index (out_point_index),
    .out_last_result (out_last_result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic longint axis_diff(input int axis,
                                       input logic signed [COORD_BITS-1:0] incoming);
    longint acc;
    acc = incoming;
    for (int k = 0; k < WIN_LEN; k++) begin
      if (k != HALF_WINDOW) acc += win[axis][k];
    end
    return acc - longint'(WIN_LEN) * longint'(win[axis][HALF_WINDOW]);
  endfunction

  function automatic longint unsigned sat_square(input longint d);
    longint unsigned mag;
    mag = (d < 0) ? -d : d;
    if (mag >= (64'd1 << SQ_IN_BITS)) return 64'(CURV_MAX) + 64'd1;
    return mag * mag;
  endfunction

  task automatic advance_window(input point_t p);
    logic signed [COORD_BITS-1:0] coord[AXES];
    longint unsigned total;
    curv_result_t res;
    coord[0] = p.x;
    coord[1] = p.y;
    coord[2] = p.z;
    if (points_seen >= WIN_LEN) begin
      total = 0;
      for (int a = 0; a < AXES; a++) total += sat_square(axis_diff(a, coord[a]));
      res.curvature   = (total > 64'(CURV_MAX)) ? CURV_MAX : total[CURV_BITS-1:0];
      res.point_index = IDX_BITS'(points_seen - HALF_WINDOW);
      res.last_result = p.eoc;
      curvature_due = {curvature_due, res};
    end
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k + 1 < WIN_LEN; k++) win[a][k] = win[a][k+1];
      win[a][WIN_LEN-1] = coord[a];
    end
    if (p.eoc) points_seen = 0;
    else if (points_seen < MAX_POINTS - 1) points_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_window(driven_point);
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          staged_point = pending_points.pop_front();
          driven_point    <= staged_point;
          in_x_coord      <= staged_point.x;
          in_y_coord      <= staged_point.y;
          in_z_coord      <= staged_point.z;
          in_end_of_cloud <= staged_point.eoc;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (curvature_due.size() == 0) begin
          $error("out item with no expected result: curvature %0d point_index %0d",
                 out_curvature, out_point_index);
          mismatches++;
        end else begin
          oldest_due = curvature_due.pop_front();
          if (out_curvature !== oldest_due.curvature) begin
            $error("curvature expected %0d actual %0d", oldest_due.curvature, out_curvature);
            mismatches++;
          end
          if (out_point_index !== oldest_due.point_index) begin
            $error("point_index expected %0d actual %0d",
                   oldest_due.point_index, out_point_index);
            mismatches++;
          end
          if (out_last_result !== oldest_due.last_result) begin
            $error("last_result expected %0d actual %0d",
                   oldest_due.last_result, out_last_result);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic queue_point(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic signed [COORD_BITS-1:0] z,
                             input logic eoc);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.eoc = eoc;
    pending_points = {pending_points, p};
    queued_total++;
  endtask

  function automatic logic signed [COORD_BITS-1:0] random_coord(
      input coord_style_t style, input logic signed [COORD_BITS-1:0] base);
    case (style)
      STYLE_WIDE: return COORD_BITS'($urandom);
      STYLE_NEAR: return base + COORD_BITS'(int'($urandom_range(2047)) - 1024);
      default: begin
        case ($urandom_range(3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic queue_cloud(input int length, input coord_style_t style);
    logic signed [COORD_BITS-1:0] bx, by, bz;
    bx = COORD_BITS'($urandom);
    by = COORD_BITS'($urandom);
    bz = COORD_BITS'($urandom);
    for (int i = 0; i < length; i++) begin
      queue_point(random_coord(style, bx), random_coord(style, by),
                  random_coord(style, bz), i == length - 1);
    end
  endtask

  task automatic queue_random_clouds(input int count);
    int start;
    int length;
    int pick;
    coord_style_t style;
    start = queued_total;
    while (queued_total - start < count) begin
      length = ($urandom_range(9) == 0) ? $urandom_range(1, WIN_LEN)
                                        : $urandom_range(WIN_LEN + 1, 40);
      pick = $urandom_range(9);
      style = (pick < 6) ? STYLE_NEAR : (pick < 8) ? STYLE_WIDE : STYLE_EDGE;
      queue_cloud(length, style);
    end
  endtask

  task automatic wait_all_done();
    while (accepted_total != queued_total || curvature_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("scan_curvature_window: mismatch");
    $finish;
  end

  initial begin
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k < WIN_LEN; k++) win[a][k] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // largest curvature: extreme center among opposite extremes
    for (int i = 0; i <= WIN_LEN; i++) begin
      if (i == HALF_WINDOW) queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      else queue_point(COORD_MAX, COORD_MAX, COORD_MAX, i == WIN_LEN);
    end
    queue_point('0, '1, COORD_MAX, 1'b1);
    for (int i = 0; i < WIN_LEN; i++) begin
      queue_point(i[0] ? COORD_MIN : COORD_MAX, i[0] ? COORD_MAX : COORD_MIN,
                  i[1] ? '1 : '0, i == WIN_LEN - 1);
    end
    wait_all_done();

    queue_cloud(WIN_LEN + 3, STYLE_NEAR);
    wait_all_done();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_table[ph];
      stall_pct = stall_table[ph];
      if (ph == 1) begin
        queue_random_clouds(PHASE_ITEMS / 2);
        wait_all_done();
        queue_random_clouds(PHASE_ITEMS / 2);
      end else begin
        queue_random_clouds(PHASE_ITEMS);
      end
      wait_all_done();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && curvature_due.size() == 0) begin
      $display("scan_curvature_window: match");
    end else begin
      $display("scan_curvature_window: mismatch");
    end
    $finish;
  end

endmodule
